FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

FILE: src/dht_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dht_pkg
// Types, constants and table builders of the direct Hermite transform core.
// ---------------------------------------------------------------------------
package dht_pkg;

   localparam int H_W         = 32;
   localparam int ACC_W       = 48;
   localparam int DEG_W       = 7;
   localparam int CNT_OUT_W   = 11;
   localparam int OPC_W       = 2;
   localparam int RSP_TDATA_W = 72;

   localparam logic signed [H_W-1:0] HSTART = 32'sd49226;

   typedef enum logic [OPC_W-1:0] {
      OP_ACCUM = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_READ,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic start;
      logic mult;
      logic advance;
   } recur_ctrl_type;

   typedef struct packed {
      logic load;
      logic mult;
      logic write;
      logic clear;
   } acc_ctrl_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] rem;
      r   = '0;
      rem = v;
      b   = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r   = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // restoring long division, used for table construction only
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return 32'(v);
   endfunction

   function automatic logic signed [31:0] grid_point(input int k, input int half_span,
                                                     input logic [63:0] span_q);
      int          d;
      logic [63:0] mag;
      logic [63:0] q;
      d   = k - half_span;
      mag = 64'((d < 0) ? -d : d) * span_q;
      q   = udiv64(mag + 64'(half_span >> 1), 64'(half_span));
      return (d < 0) ? -$signed(32'(q)) : $signed(32'(q));
   endfunction

   function automatic logic [31:0] a_coef(input int l);
      return 32'(isqrt64(udiv64(64'd1 << 61, 64'(l + 1))));
   endfunction

   function automatic logic [31:0] c_coef(input int l);
      logic [63:0] one;
      one = 64'd1 << 60;
      return 32'(isqrt64(one - udiv64(one + 64'(l), 64'(l + 1))));
   endfunction

endpackage

FILE: src/direct_hermite_transform_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// direct_hermite_transform_core
// Direct Hermite-function transform over a uniform grid of sample points.
// ---------------------------------------------------------------------------
// An accumulate request holds the port while the recurrence steps through
// every degree in a product phase (x*h), then a multiply-accumulate phase
// (a*t, with rounding), and the accumulator memory is read and written back
// once per degree in step with it. A read request holds the port until the
// result register is free, and a clear holds it for a pass over every degree.
// After reset a clearing pass zeroes the accumulator memory before the first
// request is taken. Accumulates past the last grid point only set the
// overrun flag.
module direct_hermite_transform_core #(
   parameter  int NUM_POLY     = 128,
   parameter  int HALF_SPAN    = 640,
   parameter  int SAMPLE_WIDTH = 16,
   localparam int REQ_TDATA_W  = ((SAMPLE_WIDTH + dht_pkg::DEG_W + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_TDATA_W-1:0]             req_tdata,  // sample, degree
   input  logic [dht_pkg::OPC_W-1:0]          req_tuser,  // opcode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dht_pkg::RSP_TDATA_W-1:0]    rsp_tdata   // coefficient, degree_out,
                                                          // samples_taken, overrun
);

   localparam int GRID_POINTS = 2 * HALF_SPAN + 1;
   localparam int YW          = $clog2(NUM_POLY);
   localparam int GIW         = $clog2(GRID_POINTS);
   localparam int CW          = $clog2(GRID_POINTS + 1);
   localparam int DEG_W       = dht_pkg::DEG_W;
   localparam int ACC_W       = dht_pkg::ACC_W;
   localparam int PAD_W       = dht_pkg::RSP_TDATA_W - ACC_W - DEG_W - dht_pkg::CNT_OUT_W - 1;

   dht_pkg::opcode_type         req_opcode;
   logic signed [SAMPLE_WIDTH-1:0] req_sample;
   logic [DEG_W-1:0]            req_degree;
   logic                        req_accept;

   dht_pkg::state_type          state_ff, state_in;
   logic                        phase_ff, phase_in;
   logic [YW-1:0]               y_ff, y_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic                        ovr_ff, ovr_in;
   logic [DEG_W-1:0]            deg_ff, deg_in;
   logic                        deg_ok_ff, deg_ok_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0]     rsp_coef_ff, rsp_coef_in;
   logic [DEG_W-1:0]            rsp_deg_ff, rsp_deg_in;
   logic [dht_pkg::CNT_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                        rsp_ovr_ff, rsp_ovr_in;

   dht_pkg::recur_ctrl_type     recur_ctrl;
   dht_pkg::acc_ctrl_type       acc_ctrl;
   logic [YW-1:0]               raddr;
   logic [GIW-1:0]              grid_idx;
   logic signed [dht_pkg::H_W-1:0] cur_value;
   logic signed [ACC_W-1:0]     acc_rdata;

   assign req_opcode = dht_pkg::opcode_type'(req_tuser);
   assign req_sample = $signed(req_tdata[SAMPLE_WIDTH-1:0]);
   assign req_degree = req_tdata[SAMPLE_WIDTH+DEG_W-1:SAMPLE_WIDTH];
   assign req_tready = (state_ff == dht_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign grid_idx   = (cnt_ff < CW'(GRID_POINTS)) ? GIW'(cnt_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dht_pkg::ST_SWEEP;
         phase_ff     <= 1'b0;
         y_ff         <= '0;
         cnt_ff       <= '0;
         ovr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         y_ff         <= y_in;
         cnt_ff       <= cnt_in;
         ovr_ff       <= ovr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      deg_ff      <= deg_in;
      deg_ok_ff   <= deg_ok_in;
      rsp_coef_ff <= rsp_coef_in;
      rsp_deg_ff  <= rsp_deg_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_ovr_ff  <= rsp_ovr_in;
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      y_in         = y_ff;
      cnt_in       = cnt_ff;
      ovr_in       = ovr_ff;
      deg_in       = deg_ff;
      deg_ok_in    = deg_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_coef_in  = rsp_coef_ff;
      rsp_deg_in   = rsp_deg_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_ovr_in   = rsp_ovr_ff;
      recur_ctrl   = '0;
      acc_ctrl     = '0;
      raddr        = YW'(deg_ff);

      case (state_ff)
         dht_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_opcode)
                  dht_pkg::OP_ACCUM: begin
                     if (cnt_ff < CW'(GRID_POINTS)) begin
                        recur_ctrl.start = 1'b1;
                        acc_ctrl.load    = 1'b1;
                        cnt_in           = cnt_ff + 1'b1;
                        y_in             = '0;
                        phase_in         = 1'b0;
                        state_in         = dht_pkg::ST_RUN;
                     end else begin
                        ovr_in = 1'b1;
                     end
                  end
                  dht_pkg::OP_READ: begin
                     deg_in    = req_degree;
                     deg_ok_in = 32'(req_degree) < 32'(NUM_POLY);
                     raddr     = YW'(req_degree);
                     state_in  = dht_pkg::ST_READ;
                  end
                  dht_pkg::OP_CLEAR: begin
                     cnt_in   = '0;
                     ovr_in   = 1'b0;
                     y_in     = '0;
                     state_in = dht_pkg::ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         dht_pkg::ST_RUN: begin
            if (!phase_ff) begin
               recur_ctrl.mult = 1'b1;
               acc_ctrl.mult   = 1'b1;
               raddr           = y_ff;
               phase_in        = 1'b1;
            end else begin
               recur_ctrl.advance = 1'b1;
               acc_ctrl.write     = 1'b1;
               phase_in           = 1'b0;
               if (y_ff == YW'(NUM_POLY - 1)) begin
                  y_in     = '0;
                  state_in = dht_pkg::ST_IDLE;
               end else begin
                  y_in = y_ff + 1'b1;
               end
            end
         end
         dht_pkg::ST_READ: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_coef_in  = deg_ok_ff ? acc_rdata : '0;
               rsp_deg_in   = deg_ff;
               rsp_cnt_in   = dht_pkg::CNT_OUT_W'(cnt_ff);
               rsp_ovr_in   = ovr_ff;
               state_in     = dht_pkg::ST_IDLE;
            end
         end
         dht_pkg::ST_SWEEP: begin
            acc_ctrl.write = 1'b1;
            acc_ctrl.clear = 1'b1;
            if (y_ff == YW'(NUM_POLY - 1)) begin
               y_in     = '0;
               state_in = dht_pkg::ST_IDLE;
            end else begin
               y_in = y_ff + 1'b1;
            end
         end
         default: begin
            state_in = dht_pkg::ST_IDLE;
         end
      endcase
   end

   dht_recur #(
      .NUM_POLY  (NUM_POLY),
      .HALF_SPAN (HALF_SPAN)
   ) u_recur (
      .clock     (clock),
      .ctrl      (recur_ctrl),
      .grid_idx  (grid_idx),
      .rom_idx   (y_in),
      .cur_value (cur_value)
   );

   dht_accum #(
      .NUM_POLY     (NUM_POLY),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_accum (
      .clock     (clock),
      .ctrl      (acc_ctrl),
      .sample    (req_sample),
      .cur_value (cur_value),
      .raddr     (raddr),
      .waddr     (y_ff),
      .rdata     (acc_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_ovr_ff, rsp_cnt_ff, rsp_deg_ff, rsp_coef_ff};

endmodule

FILE: src/dht_recur.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dht_recur
// Three-term Hermite recurrence with grid and coefficient tables.
// ---------------------------------------------------------------------------
module dht_recur #(
   parameter int NUM_POLY  = 128,
   parameter int HALF_SPAN = 640
) (
   input  logic                                 clock,
   input  dht_pkg::recur_ctrl_type              ctrl,
   input  logic [$clog2(2*HALF_SPAN+1)-1:0]     grid_idx,
   input  logic [$clog2(NUM_POLY)-1:0]          rom_idx,
   output logic signed [dht_pkg::H_W-1:0]       cur_value
);

   localparam int GRID_POINTS = 2 * HALF_SPAN + 1;
   localparam logic [63:0] SPAN_Q = dht_pkg::isqrt64(64'(2 * NUM_POLY + 1) << 48);

   logic signed [31:0] grid_tab [GRID_POINTS];
   logic        [31:0] a_tab    [NUM_POLY];
   logic        [31:0] c_tab    [NUM_POLY];

   for (genvar k = 0; k < GRID_POINTS; k++) begin : g_grid
      localparam logic signed [31:0] GV = dht_pkg::grid_point(k, HALF_SPAN, SPAN_Q);
      assign grid_tab[k] = GV;
   end

   for (genvar l = 0; l < NUM_POLY; l++) begin : g_coef
      localparam logic [31:0] AV = dht_pkg::a_coef(l);
      localparam logic [31:0] CV = dht_pkg::c_coef(l);
      assign a_tab[l] = AV;
      assign c_tab[l] = CV;
   end

   logic signed [31:0]            grid_rom_ff;
   logic        [31:0]            rom_a_ff;
   logic        [31:0]            rom_c_ff;
   logic signed [31:0]            x_ff;
   logic signed [dht_pkg::H_W-1:0] cur_ff;
   logic signed [dht_pkg::H_W-1:0] prev_ff;
   logic signed [63:0]            xh_ff;
   logic signed [63:0]            ch_ff;

   logic signed [31:0]            t_val;
   logic signed [64:0]            at_prod;
   logic signed [64:0]            step_sum;
   logic signed [dht_pkg::H_W-1:0] cur_in;

   always_comb begin
      t_val    = dht_pkg::sat32(xh_ff >>> 24);
      at_prod  = $signed({1'b0, rom_a_ff}) * t_val;
      step_sum = at_prod - 65'(ch_ff) + (65'sd1 <<< 29);
      cur_in   = dht_pkg::sat32(64'(step_sum >>> 30));
   end

   always_ff @(posedge clock) begin
      grid_rom_ff <= grid_tab[grid_idx];
      rom_a_ff    <= a_tab[rom_idx];
      rom_c_ff    <= c_tab[rom_idx];
      if (ctrl.start) begin
         x_ff    <= grid_rom_ff;
         cur_ff  <= dht_pkg::HSTART;
         prev_ff <= '0;
      end else if (ctrl.advance) begin
         cur_ff  <= cur_in;
         prev_ff <= cur_ff;
      end
      if (ctrl.mult) begin
         xh_ff <= x_ff * cur_ff;
         ch_ff <= $signed({2'b00, rom_c_ff}) * prev_ff;
      end
   end

   assign cur_value = cur_ff;

endmodule

FILE: src/dht_accum.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dht_accum
// Accumulator memory with read-modify-write of sample times function value.
// ---------------------------------------------------------------------------
module dht_accum #(
   parameter int NUM_POLY     = 128,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                  clock,
   input  dht_pkg::acc_ctrl_type                 ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0]        sample,
   input  logic signed [dht_pkg::H_W-1:0]        cur_value,
   input  logic [$clog2(NUM_POLY)-1:0]           raddr,
   input  logic [$clog2(NUM_POLY)-1:0]           waddr,
   output logic signed [dht_pkg::ACC_W-1:0]      rdata
);

   localparam int ACC_W  = dht_pkg::ACC_W;
   localparam int PROD_W = SAMPLE_WIDTH + dht_pkg::H_W;
   localparam int SHR    = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH - 16 : 0;
   localparam int SHL    = (SAMPLE_WIDTH < 16) ? 16 - SAMPLE_WIDTH : 0;
   localparam int PW     = PROD_W + SHL;

   logic signed [ACC_W-1:0]        acc_mem [NUM_POLY];
   logic signed [ACC_W-1:0]        rdata_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic signed [PROD_W-1:0]       sp_ff;

   logic signed [PW-1:0]    p_wide;
   logic signed [ACC_W-1:0] p_q30;
   logic signed [ACC_W:0]   acc_sum;
   logic signed [ACC_W-1:0] acc_sat;

   always_comb begin
      p_wide  = PW'(sp_ff) <<< SHL;
      p_q30   = ACC_W'(p_wide >>> SHR);
      acc_sum = {rdata_ff[ACC_W-1], rdata_ff} + {p_q30[ACC_W-1], p_q30};
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_sat = acc_sum[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= acc_mem[raddr];
      if (ctrl.write) begin
         acc_mem[waddr] <= ctrl.clear ? '0 : acc_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         sample_ff <= sample;
      end
      if (ctrl.mult) begin
         sp_ff <= sample_ff * cur_value;
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/dht_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dht_checker
// Port-level checks of the direct Hermite transform core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dht_checker #(
   parameter int NUM_POLY  = 128,
   parameter int HALF_SPAN = 640
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [dht_pkg::OPC_W-1:0]       req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dht_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam logic [10:0] GRID_LOW = 11'(2 * HALF_SPAN + 1);

   logic        req_busy_op;
   logic [6:0]  rsp_deg;
   logic [10:0] rsp_cnt;

   assign req_busy_op = req_tvalid && req_tready &&
                        (req_tuser == dht_pkg::OP_READ || req_tuser == dht_pkg::OP_CLEAR);
   assign rsp_deg     = rsp_tdata[54:48];
   assign rsp_cnt     = rsp_tdata[65:55];

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_busy_op, !req_tready)
   `ASSERT_SAME(a_overrun_full, clock, reset, rsp_tvalid && rsp_tdata[66], rsp_cnt == GRID_LOW)
   `ASSERT_SAME(a_degree_range, clock, reset, rsp_tvalid && (32'(rsp_deg) >= 32'(NUM_POLY)), rsp_tdata[47:0] == 48'd0)

endmodule

bind direct_hermite_transform_core dht_checker #(
   .NUM_POLY  (NUM_POLY),
   .HALF_SPAN (HALF_SPAN)
) u_dht_checker (.*);

FILE: sim/tb_direct_hermite_transform_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_direct_hermite_transform_core
// Self-checking bench for the direct Hermite transform core. A clocked driver
// feeds requests from a backlog queue, a clocked monitor checks every read
// response against a bit-exact model of the grid, recurrence and accumulator
// bank kept inside the bench. The run covers all opcodes, clears, a full
// grid sweep into overrun, random stalls on both ports and a long output
// hold-off that backs the core up.
// ---------------------------------------------------------------------------
module tb_direct_hermite_transform_core;

   localparam int NUM_POLY    = 128;
   localparam int HALF_SPAN   = 640;
   localparam int GRID_POINTS = 2 * HALF_SPAN + 1;
   localparam longint HSTART_Q16 = 49226;
   localparam longint ACC_MAX = 64'sd140737488355327;
   localparam longint ACC_MIN = -64'sd140737488355328;
   localparam int DRAIN_CYCLES = 2 * NUM_POLY + 50;
   localparam int HOLD_CYCLES  = 3000;

   typedef struct {
      dht_pkg::opcode_type op;
      logic [15:0]         sample;
      logic [6:0]          degree;
   } hermite_req_type;

   typedef struct {
      logic [47:0] coef;
      logic [6:0]  degree;
      logic [10:0] count;
      logic        overrun;
   } coef_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // sample, degree
   logic [1:0]  req_tuser = '0;   // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // coefficient, degree_out, samples_taken, overrun

   direct_hermite_transform_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // model state and tables
   longint      grid_x [GRID_POINTS];
   longint      a_q30 [NUM_POLY];
   longint      c_q30 [NUM_POLY];
   longint      coef_acc [NUM_POLY];
   int unsigned grid_pos;
   logic        overrun_seen;

   hermite_req_type req_backlog[$];
   coef_rsp_type    coef_expected[$];
   hermite_req_type cur_req;
   coef_rsp_type    got_rsp;
   coef_rsp_type    want_rsp;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   logic hold_trigger = 1'b0;
   int fail_count = 0;
   int n_requests = 0;
   int n_results = 0;
   int n_overrun_reads = 0;
   int gen_accums = 0;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic longint sat_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // one grid point: run the recurrence and add sample*h[l] into each degree
   task automatic sweep_degrees(input logic [15:0] sample, input longint x);
      longint s, cur, h1, h2, t, sum, acc;
      s   = $signed(sample);
      cur = HSTART_Q16;
      h1  = 0;
      h2  = 0;
      for (int y = 0; y < NUM_POLY; y++) begin
         acc = coef_acc[y] + s * cur;
         if (acc > ACC_MAX) acc = ACC_MAX;
         if (acc < ACC_MIN) acc = ACC_MIN;
         coef_acc[y] = acc;
         if (y == NUM_POLY - 1) break;
         h2  = h1;
         h1  = cur;
         t   = sat_word((x * h1) >>> 24);
         sum = a_q30[y] * t - c_q30[y] * h2;
         cur = sat_word((sum + (64'sd1 <<< 29)) >>> 30);
      end
   endtask

   task automatic hermite_update(input hermite_req_type r);
      coef_rsp_type e;
      case (r.op)
         dht_pkg::OP_ACCUM: begin
            if (grid_pos < GRID_POINTS) begin
               sweep_degrees(r.sample, grid_x[grid_pos]);
               grid_pos++;
            end else begin
               overrun_seen = 1'b1;
            end
         end
         dht_pkg::OP_READ: begin
            e.coef    = (r.degree < NUM_POLY) ? coef_acc[r.degree][47:0] : '0;
            e.degree  = r.degree;
            e.count   = grid_pos[10:0];
            e.overrun = overrun_seen;
            coef_expected.push_back(e);
         end
         dht_pkg::OP_CLEAR: begin
            foreach (coef_acc[i]) coef_acc[i] = 0;
            grid_pos     = 0;
            overrun_seen = 1'b0;
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic push_req(input dht_pkg::opcode_type op, input logic [15:0] sample,
                           input logic [6:0] degree);
      hermite_req_type r;
      r.op     = op;
      r.sample = sample;
      r.degree = degree;
      if (op == dht_pkg::OP_ACCUM) gen_accums++;
      if (op == dht_pkg::OP_CLEAR) gen_accums = 0;
      req_backlog.push_back(r);
   endtask

   task automatic queue_random(input int n, input int accum_pct, input int read_pct,
                               input int clear_pct);
      int roll;
      dht_pkg::opcode_type op;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < accum_pct) op = dht_pkg::OP_ACCUM;
         else if (roll < accum_pct + read_pct) op = dht_pkg::OP_READ;
         else if (roll < accum_pct + read_pct + clear_pct) op = dht_pkg::OP_CLEAR;
         else op = dht_pkg::OP_NOP;
         push_req(op, 16'($urandom_range(65535)), 7'($urandom_range(127)));
      end
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_tvalid || coef_expected.size() != 0)
         @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            hermite_update(cur_req);
            n_requests++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, cur_req.degree, cur_req.sample};
               req_tuser  <= cur_req.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // output hold-off counter
   always @(posedge clock) begin
      if (hold_trigger) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp.coef    = rsp_tdata[47:0];
            got_rsp.degree  = rsp_tdata[54:48];
            got_rsp.count   = rsp_tdata[65:55];
            got_rsp.overrun = rsp_tdata[66];
            if (coef_expected.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want_rsp = coef_expected.pop_front();
               check_field("coefficient", want_rsp.coef, got_rsp.coef);
               check_field("degree_out", want_rsp.degree, got_rsp.degree);
               check_field("samples_taken", want_rsp.count, got_rsp.count);
               check_field("overrun", want_rsp.overrun, got_rsp.overrun);
               n_results++;
               if (want_rsp.overrun) n_overrun_reads++;
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      #20_000_000;
      $display("tb_direct_hermite_transform_core failed");
      $finish;
   end

   initial begin
      longint unsigned span_q, mag, q, one;
      int d;
      span_q = int_sqrt(64'(2 * NUM_POLY + 1) << 48);
      for (int k = 0; k < GRID_POINTS; k++) begin
         d   = k - HALF_SPAN;
         mag = 64'((d < 0) ? -d : d) * span_q;
         q   = (mag + 64'(HALF_SPAN / 2)) / 64'(HALF_SPAN);
         grid_x[k] = (d < 0) ? -longint'(q) : longint'(q);
      end
      one = 64'd1 << 60;
      for (int l = 0; l < NUM_POLY; l++) begin
         a_q30[l] = int_sqrt((64'd1 << 61) / 64'(l + 1));
         c_q30[l] = int_sqrt(one - (one + 64'(l)) / 64'(l + 1));
         coef_acc[l] = 0;
      end
      grid_pos     = 0;
      overrun_seen = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty reads, extremes of sample and degree, nop, clear
      send_idle_pct = 37;
      recv_idle_pct = 68;
      push_req(dht_pkg::OP_READ, 16'h0000, 7'd0);
      push_req(dht_pkg::OP_READ, 16'hffff, 7'd127);
      push_req(dht_pkg::OP_NOP, 16'hffff, 7'd127);
      push_req(dht_pkg::OP_ACCUM, 16'h7fff, 7'd0);
      push_req(dht_pkg::OP_READ, 16'h0000, 7'd0);
      push_req(dht_pkg::OP_READ, 16'h0000, 7'd127);
      push_req(dht_pkg::OP_ACCUM, 16'h8000, 7'd127);
      push_req(dht_pkg::OP_ACCUM, 16'h0000, 7'd0);
      push_req(dht_pkg::OP_READ, 16'h0000, 7'd64);
      push_req(dht_pkg::OP_NOP, 16'h0000, 7'd0);
      push_req(dht_pkg::OP_READ, 16'h0000, 7'd1);
      push_req(dht_pkg::OP_CLEAR, 16'h7fff, 7'd127);
      push_req(dht_pkg::OP_READ, 16'h0000, 7'd0);
      push_req(dht_pkg::OP_READ, 16'h0000, 7'd127);
      push_req(dht_pkg::OP_ACCUM, 16'h0001, 7'd0);
      push_req(dht_pkg::OP_ACCUM, 16'hffff, 7'd0);
      push_req(dht_pkg::OP_READ, 16'h0000, 7'd1);
      push_req(dht_pkg::OP_READ, 16'h0000, 7'd126);
      push_req(dht_pkg::OP_CLEAR, 16'h0000, 7'd0);
      push_req(dht_pkg::OP_READ, 16'h0000, 7'd5);
      wait_drained();

      queue_random(20, 70, 20, 5);
      wait_drained();

      send_idle_pct = 68;
      recv_idle_pct = 37;
      queue_random(20, 70, 20, 5);
      wait_drained();

      // no idling: reads against a long output hold-off, then a full grid sweep
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_req(dht_pkg::OP_CLEAR, 16'h0000, 7'd0);
      queue_random(12, 0, 100, 0);
      hold_trigger <= 1'b1;
      @(posedge clock);
      hold_trigger <= 1'b0;
      while (gen_accums < GRID_POINTS + 10) queue_random(1, 98, 2, 0);
      push_req(dht_pkg::OP_READ, 16'h0000, 7'd0);
      push_req(dht_pkg::OP_READ, 16'hffff, 7'd127);
      push_req(dht_pkg::OP_CLEAR, 16'h0000, 7'd0);
      push_req(dht_pkg::OP_READ, 16'h0000, 7'd3);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d requests and %0d checked reads (%0d after grid overrun),",
               n_requests, n_results, n_overrun_reads);
      $display("with stalls on both ports, a long output hold-off and a full grid sweep.");
      if (fail_count == 0 && coef_expected.size() == 0) begin
         $display("tb_direct_hermite_transform_core passed");
      end else begin
         $display("tb_direct_hermite_transform_core failed");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/dht_pkg.sv
src/dht_recur.sv
src/dht_accum.sv
src/direct_hermite_transform_core.sv
src/dht_checker.sv
sim/tb_direct_hermite_transform_core.sv
